/* sv/ibt_pkg.sv */
// Package for the interval booking table.
// Holds the request and response word types, status codes and defaults.
// No dependencies.
package ibt_pkg;

  localparam int SLOT_W = 31;
  localparam int STATUS_W = 2;
  localparam int DEF_TABLE_SLOTS = 64;

  localparam logic [STATUS_W-1:0] ST_BOOKED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_start;
    logic [SLOT_W-1:0] slot_end;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic booked;
  } rsp_t;

endpackage

/* sv/interval_booking_table_core.sv */
// Top level of the interval booking table: sequencer, store and compare unit.
// Depends on ibt_pkg, ibt_store and ibt_cmp.
//
// Usage:
//   A request word (req) is taken at a rising edge where start is high and busy
//   is low. The block holds busy high while it works on the request.
//   Each request gives one response word (rsp), shown for exactly one cycle
//   with done high; the receiver cannot stall it, so capture it then.
//   An empty or reversed interval answers in the cycle after it is taken.
//   Otherwise the stored intervals are read one per cycle from the store and
//   run through a single overlap compare unit; the scan state issues the reads
//   and collects the compare hits, then the decide state registers the
//   response.
//   A new request may be given in the cycle the response is shown.
//   Reset clears the entry count and the sequencer; stored data is not cleared,
//   and entries at or above the count are never read.
module interval_booking_table_core #(
  parameter int TABLE_SLOTS = ibt_pkg::DEF_TABLE_SLOTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ibt_pkg::req_t req,
  output logic          done,
  output ibt_pkg::rsp_t rsp
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0] state;
  ibt_pkg::req_t cur;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] count;
  logic rd_pend;
  logic hit;

  logic issue;
  logic wr_en;
  logic ovl;
  ibt_pkg::req_t rd_data;

  assign busy = (state != S_IDLE);
  assign issue = (state == S_SCAN) && (scan_idx < count);
  assign wr_en = (state == S_DECIDE) && !hit && (count != FULL_CNT);

  ibt_store #(
    .SLOTS (TABLE_SLOTS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (cur),
    .rd_en   (issue),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  ibt_cmp u_cmp (
    .req   (cur),
    .entry (rd_data),
    .ovl   (ovl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      scan_idx <= '0;
      rd_pend <= 1'b0;
      hit <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur <= req;
            scan_idx <= '0;
            rd_pend <= 1'b0;
            hit <= 1'b0;
            if (req.slot_end <= req.slot_start) begin
              rsp.status <= ibt_pkg::ST_EMPTY;
              rsp.booked <= 1'b0;
              done <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end
          rd_pend <= issue;
          if (rd_pend && ovl) begin
            hit <= 1'b1;
          end
          if (!issue && !rd_pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (hit) begin
            rsp.status <= ibt_pkg::ST_OVERLAP;
            rsp.booked <= 1'b0;
          end else if (count == FULL_CNT) begin
            rsp.status <= ibt_pkg::ST_FULL;
            rsp.booked <= 1'b0;
          end else begin
            rsp.status <= ibt_pkg::ST_BOOKED;
            rsp.booked <= 1'b1;
            count <= count + 1'b1;
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/ibt_store.sv */
// Interval store for the booking table: one write port, one registered read port.
// Depends on ibt_pkg for the interval word type.
module ibt_store #(
  parameter int SLOTS = ibt_pkg::DEF_TABLE_SLOTS,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  ibt_pkg::req_t     wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output ibt_pkg::req_t     rd_data
);

  ibt_pkg::req_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/ibt_cmp.sv */
// Overlap compare unit shared across the scan of the booking table.
// Depends on ibt_pkg for the interval word type.
module ibt_cmp (
  input  ibt_pkg::req_t req,
  input  ibt_pkg::req_t entry,
  output logic          ovl
);

  assign ovl = (req.slot_start < entry.slot_end) && (entry.slot_start < req.slot_end);

endmodule

/* bench/booking_checker.sv */
`timescale 1ns / 100ps
// Checker for the interval booking table: watches request and response words,
// predicts each response from its own table of booked intervals and compares.
// Depends on ibt_pkg.
module booking_checker #(
  parameter int TABLE_SLOTS = ibt_pkg::DEF_TABLE_SLOTS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  ibt_pkg::req_t req,
  input  logic          done,
  input  ibt_pkg::rsp_t rsp,
  output int            fail_count,
  output int            outstanding
);

  logic [ibt_pkg::SLOT_W-1:0] booked_start [TABLE_SLOTS];
  logic [ibt_pkg::SLOT_W-1:0] booked_end   [TABLE_SLOTS];
  int                         n_booked = 0;
  int                         n_fail = 0;
  ibt_pkg::rsp_t              awaited_rsp [$];

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  function automatic ibt_pkg::rsp_t book_interval(input ibt_pkg::req_t r);
    ibt_pkg::rsp_t res;
    logic hit;
    int   i;
    hit = 1'b0;
    res.booked = 1'b0;
    if (r.slot_end <= r.slot_start) begin
      res.status = ibt_pkg::ST_EMPTY;
    end else begin
      for (i = 0; i < n_booked; i++) begin
        if (r.slot_start < booked_end[i] && booked_start[i] < r.slot_end) begin
          hit = 1'b1;
        end
      end
      if (hit) begin
        res.status = ibt_pkg::ST_OVERLAP;
      end else if (n_booked >= TABLE_SLOTS) begin
        res.status = ibt_pkg::ST_FULL;
      end else begin
        booked_start[n_booked] = r.slot_start;
        booked_end[n_booked] = r.slot_end;
        n_booked++;
        res.status = ibt_pkg::ST_BOOKED;
        res.booked = 1'b1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    ibt_pkg::rsp_t want;
    if (rst) begin
      n_booked = 0;
      awaited_rsp.delete();
    end else begin
      if (done === 1'b1) begin
        if (awaited_rsp.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("%0t: unexpected response word: status %0d booked %0d",
                     $realtime, rsp.status, rsp.booked);
          end
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.status !== want.status || rsp.booked !== want.booked) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: response mismatch: status exp %0d got %0d, booked exp %0d got %0d",
                       $realtime, want.status, rsp.status, want.booked, rsp.booked);
            end
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        awaited_rsp.push_back(book_interval(req));
      end
    end
    fail_count <= n_fail;
    outstanding <= awaited_rsp.size();
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Bench top for the interval booking table: clock, reset, request stimulus
// and verdict. Depends on ibt_pkg, interval_booking_table_core, booking_checker.
module tb;

  localparam int                SLOTS = ibt_pkg::DEF_TABLE_SLOTS;
  localparam int                SLOT_W = ibt_pkg::SLOT_W;
  localparam logic [SLOT_W-1:0] SLOT_MAX = '1;
  localparam logic [SLOT_W-1:0] WIN_BASE = 31'h2A5C_0000;
  localparam int                CYCLE_LIMIT = 1_000_000;
  localparam int                SETTLE_CYCLES = 80;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  ibt_pkg::req_t req = '0;
  logic          done;
  ibt_pkg::rsp_t rsp;
  int            fail_count;
  int            outstanding;
  int            cycle_count = 0;
  ibt_pkg::req_t recent [$];

  always #6 clk = ~clk;

  interval_booking_table_core #(
    .TABLE_SLOTS(SLOTS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  booking_checker #(
    .TABLE_SLOTS(SLOTS)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** interval_booking_table_core: FAILED **");
      $finish;
    end
  end

  function automatic ibt_pkg::req_t mk_req(input logic [SLOT_W-1:0] s,
                                           input logic [SLOT_W-1:0] e);
    ibt_pkg::req_t r;
    r.slot_start = s;
    r.slot_end = e;
    return r;
  endfunction

  function automatic ibt_pkg::req_t random_request();
    ibt_pkg::req_t r;
    ibt_pkg::req_t h;
    int            pick;
    pick = $urandom_range(99);
    if (pick >= 60 && pick < 80 && recent.size() == 0) pick = 40;
    if (pick < 8) begin
      r.slot_start = SLOT_W'($urandom);
      r.slot_end = SLOT_W'($urandom_range(r.slot_start, 0));
    end else if (pick < 20) begin
      r.slot_start = SLOT_W'($urandom);
      r.slot_end = SLOT_W'($urandom);
    end else if (pick < 60) begin
      r.slot_start = SLOT_W'(WIN_BASE + $urandom_range(1 << 20, 0));
      r.slot_end = SLOT_W'(r.slot_start + $urandom_range(4096, 1));
    end else if (pick < 80) begin
      h = recent[$urandom_range(recent.size() - 1, 0)];
      r.slot_start = SLOT_W'(h.slot_start + $urandom_range(2, 0));
      r.slot_end = SLOT_W'(h.slot_end - $urandom_range(2, 0));
    end else begin
      r.slot_start = SLOT_W'(SLOT_MAX - $urandom_range(65536, 1));
      r.slot_end = SLOT_W'(r.slot_start + $urandom_range(SLOT_MAX - r.slot_start, 1));
    end
    return r;
  endfunction

  task automatic send_word(input ibt_pkg::req_t r);
    start = 1'b1;
    req = r;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    if (r.slot_end > r.slot_start) begin
      recent.push_back(r);
      if (recent.size() > 256) void'(recent.pop_front());
    end
  endtask

  task automatic hold_off(input int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic random_phase(input int n, input bit with_gaps);
    int k;
    int gap_pct;
    gap_pct = 0;
    for (k = 0; k < n; k++) begin
      if (k % 100 == 0) gap_pct = with_gaps ? 20 * $urandom_range(2, 0) : 0;
      if ($urandom_range(99) < gap_pct) hold_off($urandom_range(13, 1));
      send_word(random_request());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_word(mk_req(31'd5, 31'd5));
    send_word(mk_req(31'd10, 31'd3));
    send_word(mk_req(SLOT_MAX, 31'd0));
    send_word(mk_req(SLOT_MAX, SLOT_MAX));
    send_word(mk_req(31'd0, 31'd1));
    send_word(mk_req(31'd0, 31'd1));
    send_word(mk_req(31'd1, 31'd2));
    send_word(mk_req(SLOT_MAX - 31'd1, SLOT_MAX));
    send_word(mk_req(SLOT_MAX - 31'd2, SLOT_MAX - 31'd1));
    send_word(mk_req(31'd0, SLOT_MAX));
    send_word(mk_req(31'd100, 31'd200));
    send_word(mk_req(31'd150, 31'd160));
    send_word(mk_req(31'd50, 31'd150));
    send_word(mk_req(31'd199, 31'd300));
    send_word(mk_req(31'd200, 31'd300));
    send_word(mk_req(31'd90, 31'd100));
    send_word(mk_req(31'd2, 31'd90));
    send_word(mk_req(31'h2AAA_AAAA, 31'h5555_5555));
    drain();

    random_phase(900, 1'b1);
    drain();
    random_phase(800, 1'b1);
    random_phase(300, 1'b0);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("** interval_booking_table_core: PASSED **");
    end else begin
      $display("** interval_booking_table_core: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
sv/ibt_pkg.sv
sv/ibt_store.sv
sv/ibt_cmp.sv
sv/interval_booking_table_core.sv
bench/booking_checker.sv
bench/tb.sv
